[sv/idct_pkg.sv]
// Shared types and constants of the scaled 8x8 inverse DCT.
`default_nettype none
package idct_pkg;

  // Fixed width of the coefficient and sample fields on the channels.
  localparam int FieldW = 32;

  // Q16 butterfly constants, held as 18-bit signed values.
  localparam logic signed [17:0] KSqrtHalf = 18'sd46341;
  localparam logic signed [17:0] KA        = 18'sd25080;
  localparam logic signed [17:0] KB        = 18'sd35468;
  localparam logic signed [17:0] KC        = 18'sd85627;
  localparam int                 RoundHalf = 32768;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       coef_we;   // store the accepted coefficient
    logic [5:0] coef_addr;
    logic       rd_en;     // read one entry of the current row
    logic [5:0] rd_addr;
    logic       cap_en;    // capture last read into a butterfly input lane
    logic [2:0] cap_lane;
    logic       pass;      // 0: first pass from coef store, 1: second pass
    logic       tr_we;     // write one butterfly result to the transpose store
    logic [5:0] tr_addr;
    logic [2:0] wr_lane;   // butterfly result selected for write or output
  } idct_cmd_t;

endpackage
`default_nettype wire

[sv/idct_coef_if.sv]
// Coefficient input channel.
`default_nettype none
interface idct_coef_if;
  import idct_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [FieldW-1:0] coefficient;
  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface
`default_nettype wire

[sv/idct_sample_if.sv]
// Sample output channel.
`default_nettype none
interface idct_sample_if;
  import idct_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [FieldW-1:0] sample_value;
  logic [2:0]               out_row;
  logic [2:0]               out_col;
  logic                     last;
  modport source (output valid, output sample_value, output out_row, output out_col,
                  output last, input ready);
  modport sink   (input valid, input sample_value, input out_row, input out_col,
                  input last, output ready);
endinterface
`default_nettype wire

[sv/idct_dp.sv]
// Datapath: coefficient and transpose stores, input lanes, pipelined butterfly.
`default_nettype none
module idct_dp #(
  parameter int DataW = 32
) (
  input  wire logic                              clk,
  input  wire idct_pkg::idct_cmd_t               cmd,
  input  wire logic signed [idct_pkg::FieldW-1:0] coefficient,
  output      logic signed [idct_pkg::FieldW-1:0] sample_value
);
  import idct_pkg::*;

  localparam int ProdW = DataW + 18;

  typedef logic signed [DataW-1:0] word_t;

  function automatic word_t mulq(input word_t a, input logic signed [17:0] k);
    logic signed [ProdW-1:0] p;
    p = ProdW'(a) * ProdW'(k);
    p = p + ProdW'(RoundHalf);
    return p[DataW+15:16];
  endfunction

  word_t cmem [64];
  word_t tmem [64];
  word_t cdata, tdata;
  word_t s [8];

  // stage registers
  word_t a_d26, a_s26, a_t4, a_t5, a_t1, a_t7, a_t2, a_s04;
  word_t b_d26, b_s26, b_sum21, b_d45, b_t4s, b_t1, b_t7, b_t2, b_s04;
  word_t m8, m3, m6, m2, m9, m_t4s, m_s26, m_s04, m_t7;
  word_t c1, c3, c9, c_m6, c_t4s, c_s04, c_t7, c_m8;
  word_t d_t5, d_t4, d_t3, d_t2, d_t6, d_t9, d_t7, d_t1;
  word_t d [8];

  always_ff @(posedge clk) begin
    if (cmd.coef_we) begin
      cmem[cmd.coef_addr] <= coefficient[DataW-1:0];
    end
    if (cmd.tr_we) begin
      tmem[cmd.tr_addr] <= d[cmd.wr_lane];
    end
    if (cmd.rd_en) begin
      cdata <= cmem[cmd.rd_addr];
      tdata <= tmem[cmd.rd_addr];
    end
    if (cmd.cap_en) begin
      s[cmd.cap_lane] <= cmd.pass ? tdata : cdata;
    end
  end

  // free-running butterfly pipeline; the controller waits for it to settle
  always_ff @(posedge clk) begin
    a_d26 <= s[2] - s[6];
    a_s26 <= s[2] + s[6];
    a_t4  <= s[1] + s[7];
    a_t5  <= s[5] + s[3];
    a_t1  <= s[1] - s[7];
    a_t7  <= s[0] - s[4];
    a_t2  <= s[5] - s[3];
    a_s04 <= s[0] + s[4];

    b_d26   <= a_d26;
    b_s26   <= a_s26;
    b_sum21 <= a_t2 + a_t1;
    b_d45   <= a_t4 - a_t5;
    b_t4s   <= a_t5 + a_t4;
    b_t1    <= a_t1;
    b_t7    <= a_t7;
    b_t2    <= a_t2;
    b_s04   <= a_s04;

    m8    <= mulq(b_d26, KSqrtHalf);
    m3    <= mulq(b_sum21, KA);
    m6    <= mulq(b_d45, KSqrtHalf);
    m2    <= mulq(b_t2, KB);
    m9    <= mulq(b_t1, KC);
    m_t4s <= b_t4s;
    m_s26 <= b_s26;
    m_s04 <= b_s04;
    m_t7  <= b_t7;

    c1    <= m3 + m2;
    c3    <= m9 - m3;
    c9    <= m_s26 + m8;
    c_m6  <= m6;
    c_t4s <= m_t4s;
    c_s04 <= m_s04;
    c_t7  <= m_t7;
    c_m8  <= m8;

    d_t5 <= c_m6 + c1;
    d_t4 <= c_t4s + c3;
    d_t3 <= c3 + c_m6;
    d_t2 <= c_s04 - c9;
    d_t6 <= c_s04 + c9;
    d_t9 <= c_t7 - c_m8;
    d_t7 <= c_t7 + c_m8;
    d_t1 <= c1;

    d[0] <= d_t6 + d_t4;
    d[1] <= d_t7 + d_t3;
    d[2] <= d_t9 + d_t5;
    d[3] <= d_t2 + d_t1;
    d[4] <= d_t2 - d_t1;
    d[5] <= d_t9 - d_t5;
    d[6] <= d_t7 - d_t3;
    d[7] <= d_t6 - d_t4;
  end

  assign sample_value = FieldW'(d[cmd.wr_lane]);

endmodule
`default_nettype wire

[sv/idct_ctrl.sv]
// Controller: load count, pass and row sequencing, output handshake.
`default_nettype none
module idct_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [2:0]           out_row,
  output      logic [2:0]           out_col,
  output      logic                 out_last,
  output      idct_pkg::idct_cmd_t  cmd
);
  import idct_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [3:0] ReadLast = 4'd8;  // 8 reads, then the capture of the last read
  localparam logic [3:0] CalcLast = 4'd5;  // six butterfly stages

  logic [2:0] state, state_next;
  logic [5:0] load_count, load_count_next;
  logic [3:0] cnt, cnt_next;
  logic [2:0] row, row_next;
  logic       pass, pass_next;
  logic       in_acc, out_acc;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign out_row   = row;
  assign out_col   = cnt[2:0];
  assign out_last  = (row == 3'd7) && (cnt[2:0] == 3'd7);

  always_comb begin
    cmd.coef_we   = in_acc;
    cmd.coef_addr = load_count;
    cmd.rd_en     = (state == S_READ) && !cnt[3];
    cmd.rd_addr   = {row, cnt[2:0]};
    cmd.cap_en    = (state == S_READ) && (cnt != 4'd0);
    cmd.cap_lane  = cnt[2:0] - 3'd1;
    cmd.pass      = pass;
    cmd.tr_we     = (state == S_WRITE);
    cmd.tr_addr   = {cnt[2:0], row};
    cmd.wr_lane   = cnt[2:0];
  end

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    cnt_next        = cnt;
    row_next        = row;
    pass_next       = pass;
    case (state)
      S_LOAD: begin
        if (in_acc) begin
          load_count_next = load_count + 6'd1;
          if (load_count == 6'd63) begin
            state_next = S_READ;
            cnt_next   = '0;
            row_next   = '0;
            pass_next  = 1'b0;
          end
        end
      end
      S_READ: begin
        cnt_next = cnt + 4'd1;
        if (cnt == ReadLast) begin
          state_next = S_CALC;
          cnt_next   = '0;
        end
      end
      S_CALC: begin
        cnt_next = cnt + 4'd1;
        if (cnt == CalcLast) begin
          state_next = pass ? S_EMIT : S_WRITE;
          cnt_next   = '0;
        end
      end
      S_WRITE: begin
        cnt_next = cnt + 4'd1;
        if (cnt[2:0] == 3'd7) begin
          state_next = S_READ;
          cnt_next   = '0;
          if (row == 3'd7) begin
            row_next  = '0;
            pass_next = 1'b1;
          end else begin
            row_next = row + 3'd1;
          end
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          cnt_next = cnt + 4'd1;
          if (cnt[2:0] == 3'd7) begin
            cnt_next = '0;
            if (row == 3'd7) begin
              state_next = S_LOAD;
            end else begin
              state_next = S_READ;
              row_next   = row + 3'd1;
            end
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      cnt        <= '0;
      row        <= '0;
      pass       <= 1'b0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      cnt        <= cnt_next;
      row        <= row_next;
      pass       <= pass_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("load and emit overlap");

  a_block_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && load_count == 6'd63) |=> (state == S_READ && !pass))
    else $error("transform did not start on the 64th coefficient");

  a_block_end: assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_last) |=> (in_ready && load_count == 6'd0))
    else $error("not back to loading after the last sample");

  a_tr_first_pass: assert property (@(posedge clk) disable iff (rst)
    cmd.tr_we |-> !pass) else $error("transpose write in second pass");

endmodule
`default_nettype wire

[sv/idct_8x8_scaled_fixed.sv]
// Top level of the scaled 8x8 inverse DCT: controller plus datapath.
//
//  channel   dir  per request                                   notes
//  in_ch     in   coefficient (32b signed)                      row-major, 64 per block
//  out_ch    out  sample_value (32b signed), out_row, out_col,  row-major, last on 64th
//                 last
//
// Flow: a block is loaded one coefficient a cycle while in_ch is valid, then run as 16
//   row passes of reads, butterfly and write (first pass) or emit (second pass);
//   the single read port of each store and the shared butterfly pipeline make the
//   passes run one at a time.
// Reset: rst, synchronous, returns to loading with an empty count; stores are not cleared.
// Stalls: out_ch back-pressure holds the current sample; no coefficient is taken
//   until the whole block has been emitted.
`default_nettype none
module idct_8x8_scaled_fixed #(
  parameter int DATA_WIDTH = 32   // internal wrap width, 16 to 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  idct_coef_if.sink   in_ch,
  idct_sample_if.source out_ch
);
  import idct_pkg::*;

  idct_cmd_t cmd;

  idct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_last  (out_ch.last),
    .cmd       (cmd)
  );

  // butterfly results are wrapped to DATA_WIDTH and sign-extended on the way out
  idct_dp #(
    .DataW (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .coefficient  (in_ch.coefficient),
    .sample_value (out_ch.sample_value)
  );

endmodule
`default_nettype wire

[tb/tb_idct_8x8_scaled_fixed.sv]
// Randomised self-checking testbench for the scaled 8x8 inverse DCT.
`default_nettype none
module tb_idct_8x8_scaled_fixed;
  timeunit 1ns;
  timeprecision 1ps;
  import idct_pkg::*;

  // Expected sample of the output block
  typedef struct {
    logic signed [FieldW-1:0] sample_value;
    logic [2:0]               out_row;
    logic [2:0]               out_col;
    logic                     last;
  } sample_t;

  // Predicts the samples of each block and checks them in order.
  class idct_scoreboard;
    logic signed [31:0] coef_mem [64];
    int unsigned        load_cnt;
    sample_t            pending_samples[$];
    int unsigned        n_errors;
    int unsigned        n_samples;

    function new();
      load_cnt = 0;
      n_errors = 0;
      n_samples = 0;
    endfunction

    // Q16 product with round-half-up, wrapped to 32 bits
    function automatic logic signed [31:0] qmul(logic signed [31:0] a,
                                                logic signed [17:0] k);
      logic signed [63:0] p;
      p = 64'(a) * 64'(k) + 64'(RoundHalf);
      return 32'(p >>> 16);
    endfunction

    // One 8-point butterfly; sums wrap at 32 bits
    function automatic void row_idct(input logic signed [31:0] s[8],
                                     output logic signed [31:0] d[8]);
      logic signed [31:0] t1, t2, t3, t4, t5, t6, t7, t8, t9;
      t8 = qmul(s[2] - s[6], KSqrtHalf);
      t4 = s[1] + s[7];
      t5 = s[5] + s[3];
      t1 = s[1] - s[7];
      t7 = s[0] - s[4];
      t2 = s[5] - s[3];
      t3 = qmul(t2 + t1, KA);
      t6 = qmul(t4 - t5, KSqrtHalf);
      t4 = t5 + t4;
      t2 = qmul(t2, KB);
      t9 = qmul(t1, KC);
      t1 = t3 + t2;
      t5 = t6 + t1;
      t3 = t9 - t3;
      t4 = t4 + t3;
      t3 = t3 + t6;
      t9 = s[2] + s[6] + t8;
      t6 = s[0] + s[4];
      t2 = t6 - t9;
      t6 = t6 + t9;
      t9 = t7 - t8;
      t7 = t7 + t8;
      d[0] = t6 + t4; d[1] = t7 + t3; d[2] = t9 + t5; d[3] = t2 + t1;
      d[4] = t2 - t1; d[5] = t9 - t5; d[6] = t7 - t3; d[7] = t6 - t4;
    endfunction

    function void note_coefficient(logic signed [31:0] c);
      logic signed [31:0] lane[8];
      logic signed [31:0] res[8];
      logic signed [31:0] tr[64];
      sample_t            smp;
      coef_mem[load_cnt] = c;
      load_cnt = (load_cnt + 1) % 64;
      if (load_cnt != 0) return;
      for (int r = 0; r < 8; r++) begin
        for (int k = 0; k < 8; k++) lane[k] = coef_mem[r*8 + k];
        row_idct(lane, res);
        for (int k = 0; k < 8; k++) tr[k*8 + r] = res[k];
      end
      for (int r = 0; r < 8; r++) begin
        for (int k = 0; k < 8; k++) lane[k] = tr[r*8 + k];
        row_idct(lane, res);
        for (int k = 0; k < 8; k++) begin
          smp.sample_value = res[k];
          smp.out_row = 3'(r);
          smp.out_col = 3'(k);
          smp.last = (r == 7 && k == 7);
          pending_samples.push_back(smp);
        end
      end
    endfunction

    function void check_sample(sample_t got);
      sample_t exp_s;
      n_samples++;
      if (pending_samples.size() == 0) begin
        $error("sample with none expected: value %0d", got.sample_value);
        n_errors++;
        return;
      end
      exp_s = pending_samples.pop_front();
      if (got.sample_value !== exp_s.sample_value) begin
        $error("sample_value: expected %0d, got %0d", exp_s.sample_value,
               got.sample_value);
        n_errors++;
      end
      if (got.out_row !== exp_s.out_row) begin
        $error("out_row: expected %0d, got %0d", exp_s.out_row, got.out_row);
        n_errors++;
      end
      if (got.out_col !== exp_s.out_col) begin
        $error("out_col: expected %0d, got %0d", exp_s.out_col, got.out_col);
        n_errors++;
      end
      if (got.last !== exp_s.last) begin
        $error("last: expected %0d, got %0d", exp_s.last, got.last);
        n_errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  idct_coef_if   coef_ch ();
  idct_sample_if sample_ch ();

  idct_8x8_scaled_fixed #(.DATA_WIDTH(32)) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (coef_ch.sink),
    .out_ch(sample_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  idct_scoreboard sb = new();

  // Long hold-off on the sample side, requested by the driver
  bit          hold_off_req = 1'b0;
  bit          stim_done    = 1'b0;
  int unsigned n_coefs      = 0;
  int unsigned n_blocks     = 0;

  initial begin
    coef_ch.valid       = 1'b0;
    coef_ch.coefficient = '0;
    sample_ch.ready     = 1'b0;
  end

  // Offer one coefficient request and wait for it to be taken.
  // valid stays high into the next request when no gap is drawn.
  task automatic send_coef(logic signed [31:0] c, bit no_gap = 1'b0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;   // bursts with no idling
    if (gap != 0) begin
      coef_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coef_ch.valid       <= 1'b1;
    coef_ch.coefficient <= c;
    do @(posedge clk); while (!coef_ch.ready);
    sb.note_coefficient(c);
    n_coefs++;
    if (n_coefs % 64 == 0) n_blocks++;
  endtask

  task automatic drop_valid();
    coef_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random coefficient: small values half the time, else extremes, zero or full range
  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return $urandom();
      4:       return 32'sd0;
      default: return 32'($signed(17'($urandom_range(0, 131071))));
    endcase
  endfunction

  task automatic send_block(int kind);
    logic signed [31:0] c;
    for (int i = 0; i < 64; i++) begin
      case (kind)
        0:       c = (i == 0) ? 32'sd1024 : 32'sd0;            // zero AC
        1:       c = 32'sh7fffffff;                            // overflow high
        2:       c = 32'sh80000000;                            // overflow low
        3:       c = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
        4:       c = (i % 8 == 0) ? rand_coef() : 32'sd0;      // DC-only rows
        default: c = rand_coef();
      endcase
      send_coef(c);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_samples.size() != 0) @(posedge clk);
  endtask

  // Sample side: random stalls, plus a long hold-off on request
  initial begin
    sample_t got;
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        sample_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off_req = 1'b0;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
      if (stall != 0) begin
        sample_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      sample_ch.ready <= 1'b1;
      do @(posedge clk); while (!sample_ch.valid);
      got.sample_value = sample_ch.sample_value;
      got.out_row      = sample_ch.out_row;
      got.out_col      = sample_ch.out_col;
      got.last         = sample_ch.last;
      sb.check_sample(got);
    end
  end

  // Coefficient side
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: zero-AC block and a full-scale block back to back
    send_block(0);
    send_block(1);
    drop_valid();
    wait_drained();           // sender pauses until every sample is back
    // Receiver holds off while the next blocks are offered, so input stalls
    hold_off_req = 1'b1;
    send_block(3);
    // Random part: a fully random block
    send_block(5);
    drop_valid();
    wait_drained();
    repeat (500) @(posedge clk);
    stim_done = 1'b1;
  end

  // Normal end
  initial begin
    wait (stim_done);
    $display("covered %0d coefficients in %0d blocks, %0d samples checked",
             n_coefs, n_blocks, sb.n_samples);
    if (sb.n_errors == 0 && sb.pending_samples.size() == 0) begin
      $display("idct_8x8_scaled_fixed regression: pass");
    end else begin
      $display("idct_8x8_scaled_fixed regression: fail");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("idct_8x8_scaled_fixed regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
